// ===== hw/rtl/wpm_pkg.sv =====
// Shared types and constants for the wildcard pattern matcher.
`default_nettype none

package wpm_pkg;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_BEGIN  = 2'd1,
        OP_TEXT   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    localparam logic [7:0] STAR_BYTE = 8'd42;
    localparam logic [7:0] ANY_BYTE  = 8'd63;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic       append;
        logic       clear;
        logic [7:0] symbol;
    } t_cmd;

    // Update wave that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic       valid;
        logic       is_text;
        logic [7:0] symbol;
        logic       new_bit;
        logic       old_bit;
        logic       result;
    } t_wave;

endpackage

`default_nettype wire

// ===== hw/rtl/wildcard_pattern_matcher.sv =====
// Append and clear words take effect when accepted; a begin or text word gives its
// result word after the update wave leaves the last cell of the row, later while
// the previous result word is stalled.
// Until a begin or text word has its result word registered, the wave walking the row
// one position per cycle, no new word is taken; when idle, append and clear every cycle.
// Reset: pattern length zero, match row empty (position zero true), no word pending.
`default_nettype none

module wildcard_pattern_matcher #(
    parameter int PATTERN_MAX = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_symbol,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_matched
);

    localparam int LW = $clog2(PATTERN_MAX + 1);

    logic           r_busy;
    logic           r_row0;
    logic [LW-1:0]  r_len;
    logic           r_out_valid;
    logic           r_out;
    logic           r_hold;
    logic           r_hold_val;
    logic           w_accept;
    logic           w_launch;
    logic           w_out_free;
    wpm_pkg::t_op   w_op;
    wpm_pkg::t_cmd  w_cmd;
    wpm_pkg::t_wave w_wave [PATTERN_MAX + 1];

    assign w_op       = wpm_pkg::t_op'(i_op);
    assign o_in_ready = !r_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_launch   = w_accept && (w_op == wpm_pkg::OP_BEGIN || w_op == wpm_pkg::OP_TEXT);
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_cmd.append = w_accept && (w_op == wpm_pkg::OP_APPEND) &&
                          (r_len != LW'(PATTERN_MAX));
    assign w_cmd.clear  = w_accept && (w_op == wpm_pkg::OP_CLEAR);
    assign w_cmd.symbol = i_symbol;

    // Position zero is handled here; the wave enters the first cell directly.
    always_comb begin
        w_wave[0].valid   = w_launch;
        w_wave[0].is_text = (w_op == wpm_pkg::OP_TEXT);
        w_wave[0].symbol  = i_symbol;
        w_wave[0].new_bit = (w_op == wpm_pkg::OP_BEGIN);
        w_wave[0].old_bit = r_row0;
        w_wave[0].result  = (r_len == '0) ? (w_op == wpm_pkg::OP_BEGIN) : 1'b0;
    end

    for (genvar g = 1; g <= PATTERN_MAX; g++) begin : g_cell
        wpm_cell #(
            .IDX (g),
            .LW  (LW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_len   (r_len),
            .i_wave  (w_wave[g-1]),
            .o_wave  (w_wave[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_row0      <= 1'b1;
            r_len       <= '0;
            r_out_valid <= 1'b0;
            r_hold      <= 1'b0;
        end else begin
            if (w_cmd.append) begin
                r_len <= r_len + LW'(1);
            end
            if (w_cmd.clear) begin
                r_len  <= '0;
                r_row0 <= 1'b1;
            end
            if (w_launch) begin
                r_row0 <= (w_op == wpm_pkg::OP_BEGIN);
                r_busy <= 1'b1;
            end

            // A finished result parks in the hold stage while the output word waits.
            if (w_out_free) begin
                if (r_hold) begin
                    r_out_valid <= 1'b1;
                    r_hold      <= 1'b0;
                    r_busy      <= 1'b0;
                end else if (w_wave[PATTERN_MAX].valid) begin
                    r_out_valid <= 1'b1;
                    r_busy      <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (w_wave[PATTERN_MAX].valid) begin
                r_hold <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_hold ? r_hold_val : w_wave[PATTERN_MAX].result;
        end
        if (!w_out_free && w_wave[PATTERN_MAX].valid) begin
            r_hold_val <= w_wave[PATTERN_MAX].result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_out;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(PATTERN_MAX))
        else $error("pattern length exceeds capacity");

    a_hold_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold |-> (r_out_valid && r_busy))
        else $error("hold stage filled without a waiting output word");

    a_launch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_launch |=> r_busy)
        else $error("begin or text word accepted without marking busy");

    a_clear_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |=> (r_row0 && r_len == '0))
        else $error("clear did not restore the empty row");

    a_wave_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wave[PATTERN_MAX].valid |-> r_busy)
        else $error("update wave left the row while idle");

endmodule

`default_nettype wire

// ===== hw/rtl/wpm_cell.sv =====
// One pattern position: stored pattern byte, its match bit and a wave stage.
`default_nettype none

module wpm_cell #(
    parameter int IDX = 1,
    parameter int LW  = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire wpm_pkg::t_cmd  i_cmd,
    input  wire logic [LW-1:0] i_len,
    input  wire wpm_pkg::t_wave i_wave,
    output wpm_pkg::t_wave      o_wave
);

    logic [7:0]     r_pat;
    logic           r_bit;
    logic           r_wave_valid;
    wpm_pkg::t_wave r_wave;
    logic           n_bit;
    logic           w_active;
    logic           w_is_star;
    logic           w_wr;

    assign w_active  = (i_len >= LW'(IDX));
    assign w_is_star = (r_pat == wpm_pkg::STAR_BYTE);
    assign w_wr      = i_cmd.append && (i_len == LW'(IDX - 1));

    always_comb begin
        if (!w_active) begin
            n_bit = 1'b0;
        end else if (!i_wave.is_text) begin
            // A begin only lets the empty-text match run through leading stars.
            n_bit = i_wave.new_bit && w_is_star;
        end else if (w_is_star) begin
            n_bit = r_bit || i_wave.new_bit;
        end else if (r_pat == wpm_pkg::ANY_BYTE || r_pat == i_wave.symbol) begin
            n_bit = i_wave.old_bit;
        end else begin
            n_bit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_pat <= i_cmd.symbol;
        end
        r_wave.valid   <= i_wave.valid;
        r_wave.is_text <= i_wave.is_text;
        r_wave.symbol  <= i_wave.symbol;
        r_wave.new_bit <= n_bit;
        r_wave.old_bit <= r_bit;
        r_wave.result  <= (i_len == LW'(IDX)) ? n_bit : i_wave.result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit        <= 1'b0;
            r_wave_valid <= 1'b0;
        end else begin
            r_wave_valid <= i_wave.valid;
            if (i_cmd.clear || w_wr) begin
                r_bit <= 1'b0;
            end else if (i_wave.valid) begin
                r_bit <= n_bit;
            end
        end
    end

    always_comb begin
        o_wave       = r_wave;
        o_wave.valid = r_wave_valid;
    end

endmodule

`default_nettype wire
